>>> design/ksi_pkg.sv
// Shared types, constants and codes for the k-way set intersection core.
package ksi_pkg;

   // Sizing of the count store and the job
   localparam int MAX_SETS    = 16;
   localparam int VALUE_SPACE = 1024;
   localparam int VAL_W       = $clog2(VALUE_SPACE);
   localparam int CUR_W       = $clog2(VALUE_SPACE + 1);
   localparam int CNT_W       = $clog2(MAX_SETS + 1);

   // Fixed port widths
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int MEMBER_W = 10;
   localparam int SETCNT_W = 5;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_START = 2'd0,
      KIND_ELEM  = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_FETCH = 2'd3
   } kind_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_MEMBER = 2'd0,
      ST_NONE   = 2'd1,
      ST_ERROR  = 2'd2,
      ST_OPEN   = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       clear_job;    // reset job state, restart the clearing sweep
      logic       clear_write;  // zero one count, advance the sweep
      logic       elem_latch;   // latch element address, read its count
      logic       elem_fail;    // set the sticky error
      logic       elem_write;   // write back count plus one
      logic       close_set;    // count one more closed set
      logic       scan_read;    // read count at the cursor
      logic       scan_next;    // advance the cursor, read the next count
      logic       scan_end;     // park the cursor at the end
      logic       rsp_valid;    // emit a response
      status_type rsp_status;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic elem_bad;
      logic input_err;
      logic sets_open;
      logic scan_empty;
      logic hit;
      logic cursor_last;
      logic clear_last;
   } stat_type;

endpackage

>>> design/ksi_ctrl.sv
// Controller state machine for the k-way set intersection core.
module ksi_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ksi_pkg::KIND_W-1:0]   req_kind,
   input  ksi_pkg::stat_type            stat,
   output logic                         busy,
   output ksi_pkg::cmd_type             cmd
);
   import ksi_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_ELEM_WR,
      S_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Decode requests and sequence the multi-cycle work
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_status = ST_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (kind_type'(req_kind))
                  KIND_START: begin
                     cmd.clear_job = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  KIND_ELEM: begin
                     if (!stat.input_err) begin
                        if (stat.elem_bad) begin
                           cmd.elem_fail = 1'b1;
                        end else begin
                           cmd.elem_latch = 1'b1;
                           state_in       = S_ELEM_WR;
                        end
                     end
                  end
                  KIND_CLOSE: begin
                     cmd.close_set = stat.sets_open;
                  end
                  KIND_FETCH: begin
                     if (stat.input_err) begin
                        cmd.rsp_valid  = 1'b1;
                        cmd.rsp_status = ST_ERROR;
                     end else if (stat.sets_open) begin
                        cmd.rsp_valid  = 1'b1;
                        cmd.rsp_status = ST_OPEN;
                     end else if (stat.scan_empty) begin
                        cmd.scan_end   = 1'b1;
                        cmd.rsp_valid  = 1'b1;
                        cmd.rsp_status = ST_NONE;
                     end else begin
                        cmd.scan_read = 1'b1;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ELEM_WR: begin
            cmd.elem_write = 1'b1;
            state_in       = S_IDLE;
         end
         S_SCAN: begin
            if (stat.hit) begin
               cmd.scan_next  = 1'b1;
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_status = ST_MEMBER;
               state_in       = S_IDLE;
            end else if (stat.cursor_last) begin
               cmd.scan_end   = 1'b1;
               cmd.rsp_valid  = 1'b1;
               cmd.rsp_status = ST_NONE;
               state_in       = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Hold state; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/ksi_dp.sv
// Datapath of the k-way set intersection core: count store, job state, response.
module ksi_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [ksi_pkg::VALUE_W-1:0]  req_value,
   input  logic                           csr_wr_en,
   input  logic [ksi_pkg::SETCNT_W-1:0]   csr_wr_data,
   input  ksi_pkg::cmd_type               cmd,
   output ksi_pkg::stat_type              stat,
   output logic                           rsp_strobe,
   output logic [ksi_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ksi_pkg::MEMBER_W-1:0]   rsp_member
);
   import ksi_pkg::*;

   // Count store
   logic [CNT_W-1:0]    count_mem [VALUE_SPACE];
   logic [CNT_W-1:0]    rd_data_ff;
   logic [VAL_W-1:0]    rd_addr;
   logic                rd_en;
   logic [VAL_W-1:0]    wr_addr;
   logic [CNT_W-1:0]    wr_data;
   logic                wr_en;

   // Job state
   logic [SETCNT_W-1:0] set_count_ff;
   logic [VAL_W-1:0]    clr_addr_ff;
   logic [VAL_W-1:0]    elem_addr_ff;
   logic [VAL_W-1:0]    prev_ff;
   logic                has_elem_ff;
   logic [CNT_W-1:0]    closed_ff;
   logic                err_ff;
   logic [CUR_W-1:0]    cursor_ff;
   logic [CNT_W-1:0]    k_sets;
   logic [VAL_W-1:0]    raw_addr;
   logic                raw_range_bad;

   // Response registers
   logic                   rsp_strobe_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [MEMBER_W-1:0]    rsp_member_ff;

   // Clamp the set count to the supported maximum
   always_comb begin
      if (32'(set_count_ff) > MAX_SETS) begin
         k_sets = CNT_W'(MAX_SETS);
      end else begin
         k_sets = CNT_W'(set_count_ff);
      end
   end

   // Check the incoming element
   assign raw_addr      = VAL_W'($unsigned(req_value));
   assign raw_range_bad = req_value[VALUE_W-1] ||
                          (32'($unsigned(req_value)) >= VALUE_SPACE);

   assign stat.elem_bad    = raw_range_bad || (closed_ff >= k_sets) ||
                             (has_elem_ff && (raw_addr <= prev_ff));
   assign stat.input_err   = err_ff;
   assign stat.sets_open   = (closed_ff < k_sets);
   assign stat.scan_empty  = (k_sets == '0) || (cursor_ff == CUR_W'(VALUE_SPACE));
   assign stat.hit         = (rd_data_ff == k_sets);
   assign stat.cursor_last = (cursor_ff == CUR_W'(VALUE_SPACE - 1));
   assign stat.clear_last  = (clr_addr_ff == VAL_W'(VALUE_SPACE - 1));

   // Select the read and write ports of the count store
   always_comb begin
      rd_en   = cmd.elem_latch || cmd.scan_read || cmd.scan_next;
      rd_addr = raw_addr;
      if (cmd.scan_read) begin
         rd_addr = VAL_W'(cursor_ff);
      end else if (cmd.scan_next) begin
         rd_addr = VAL_W'(cursor_ff + 1'b1);
      end
      wr_en   = cmd.clear_write || cmd.elem_write;
      wr_addr = cmd.clear_write ? clr_addr_ff : elem_addr_ff;
      wr_data = cmd.clear_write ? '0 : rd_data_ff + 1'b1;
   end

   // Count store access, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= count_mem[rd_addr];
      end
   end

   // Latch the element address for the write back
   always_ff @(posedge clock) begin
      if (cmd.elem_latch) begin
         elem_addr_ff <= raw_addr;
      end
   end

   // Hold configuration and job state
   always_ff @(posedge clock) begin
      if (reset) begin
         set_count_ff <= '0;
         clr_addr_ff  <= '0;
         prev_ff      <= '0;
         has_elem_ff  <= 1'b0;
         closed_ff    <= '0;
         err_ff       <= 1'b0;
         cursor_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            set_count_ff <= csr_wr_data;
         end
         if (cmd.clear_job) begin
            clr_addr_ff <= '0;
            prev_ff     <= '0;
            has_elem_ff <= 1'b0;
            closed_ff   <= '0;
            err_ff      <= 1'b0;
            cursor_ff   <= '0;
         end
         if (cmd.clear_write) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.elem_fail) begin
            err_ff <= 1'b1;
         end
         if (cmd.elem_latch) begin
            prev_ff     <= raw_addr;
            has_elem_ff <= 1'b1;
         end
         if (cmd.close_set) begin
            closed_ff   <= closed_ff + 1'b1;
            has_elem_ff <= 1'b0;
            prev_ff     <= '0;
         end
         if (cmd.scan_next) begin
            cursor_ff <= cursor_ff + 1'b1;
         end
         if (cmd.scan_end) begin
            cursor_ff <= CUR_W'(VALUE_SPACE);
         end
      end
   end

   // Register the response for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_valid;
      end
      if (cmd.rsp_valid) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == ST_MEMBER) begin
            rsp_member_ff <= MEMBER_W'(cursor_ff);
         end else begin
            rsp_member_ff <= '0;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_member = rsp_member_ff;

endmodule

>>> design/k_set_intersection_core.sv
// Top level of the k-way sorted set intersection core.
//
//  Channel   Ports                          Handshake
//  request   req_kind, req_value            taken when start high and busy low
//  response  rsp_status, rsp_member         rsp_strobe, one cycle, no back-pressure
//  config    csr_wr_data (set_count)        csr_wr_en, written at the clock edge
//
// A close or a rejected element is done on acceptance; an accepted element reads
// its count, then writes it back plus one in S_ELEM_WR through the write port.
// A fetch answers in the cycle after acceptance for the error, open and exhausted
// cases; otherwise the core scans the count store value by value through its
// registered read and answers once it finds a member or reaches the last value.
// Reset and every start clear all VALUE_SPACE (1024) counts in a pass with
// busy high. The receiver cannot stall; each response is shown for one cycle.
module k_set_intersection_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ksi_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [ksi_pkg::VALUE_W-1:0]   req_value,
   output logic                                 busy,
   output logic                                 rsp_strobe,
   output logic [ksi_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ksi_pkg::MEMBER_W-1:0]         rsp_member,
   input  logic                                 csr_wr_en,
   input  logic [ksi_pkg::SETCNT_W-1:0]         csr_wr_data
);
   import ksi_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ksi_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   ksi_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_value   (req_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_member  (rsp_member)
   );

   // A response follows an accepted request or ongoing work
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) || $past(start))
      else $error("response without a preceding request");

   // Member field is zero unless a member is returned
   a_member_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_MEMBER) |-> rsp_member == '0)
      else $error("member nonzero on a status response");

   // A start request enters the clearing pass
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_START) |=> busy && !rsp_strobe)
      else $error("start did not begin the clearing pass");

   // Reset begins the clearing pass
   a_reset_clear: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

endmodule

>>> dv/k_set_intersection_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the k-way set intersection core, directed and random jobs.
module k_set_intersection_core_test;
   import ksi_pkg::*;

   localparam int RANDOM_REQUESTS = 650;
   localparam int SETTLE_CYCLES   = VALUE_SPACE + 100;
   localparam int LIMIT_CYCLES    = 3_000_000;

   typedef struct {
      kind_type                  kind;
      logic signed [VALUE_W-1:0] value;
   } request_type;

   typedef struct {
      status_type          status;
      logic [MEMBER_W-1:0] member;
   } answer_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       start       = 1'b0;
   logic [KIND_W-1:0]          req_kind    = KIND_START;
   logic signed [VALUE_W-1:0]  req_value   = '0;
   logic                       csr_wr_en   = 1'b0;
   logic [SETCNT_W-1:0]        csr_wr_data = '0;
   logic                       busy;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic [MEMBER_W-1:0]        rsp_member;

   request_type pending_requests[$];
   answer_type  answers_due[$];
   int          failures        = 0;
   int          cycles          = 0;
   int          queued          = 0;
   int          idle_left       = 0;
   int          programmed_sets = 0;
   bit          idle_on         = 1'b1;
   logic        req_taken       = 1'b0;

   // Predicted job state
   logic [CNT_W-1:0] hits [VALUE_SPACE];
   logic [VAL_W-1:0] last_elem;
   bit               set_open;
   bit               bad_input;
   int               closed_sets;
   int               scan;
   int               sets_wanted;

   k_set_intersection_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_kind    (req_kind),
      .req_value   (req_value),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_member  (rsp_member),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hold reset at the start of the run, releasing it at a falling edge
   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin : watchdog
      wait (cycles >= LIMIT_CYCLES);
      $display("k_set_intersection_core verification failed");
      $finish;
   end

   function automatic void wipe_job();
      foreach (hits[i]) hits[i] = '0;
      last_elem   = '0;
      set_open    = 1'b0;
      bad_input   = 1'b0;
      closed_sets = 0;
      scan        = 0;
   endfunction

   // Apply one request to the job state; return 1 when it yields an answer
   function automatic bit step_intersection(input request_type req, output answer_type ans);
      int k;
      int v;
      bit found;
      bit answers;
      k          = (sets_wanted > MAX_SETS) ? MAX_SETS : sets_wanted;
      v          = int'(req.value);
      found      = 1'b0;
      answers    = 1'b0;
      ans.status = ST_NONE;
      ans.member = '0;
      case (req.kind)
         KIND_START: begin
            wipe_job();
         end
         KIND_ELEM: begin
            if (!bad_input) begin
               if (v < 0 || v >= VALUE_SPACE || closed_sets >= k ||
                   (set_open && v <= int'(last_elem))) begin
                  bad_input = 1'b1;
               end else begin
                  hits[v]   = hits[v] + 1'b1;
                  last_elem = v[VAL_W-1:0];
                  set_open  = 1'b1;
               end
            end
         end
         KIND_CLOSE: begin
            if (closed_sets < k) begin
               closed_sets++;
               set_open  = 1'b0;
               last_elem = '0;
            end
         end
         KIND_FETCH: begin
            answers = 1'b1;
            if (bad_input) begin
               ans.status = ST_ERROR;
            end else if (closed_sets < k) begin
               ans.status = ST_OPEN;
            end else begin
               // advance the cursor to the next value held by every set
               while (k > 0 && !found && scan < VALUE_SPACE) begin
                  if (int'(hits[scan]) == k) begin
                     found      = 1'b1;
                     ans.status = ST_MEMBER;
                     ans.member = scan[MEMBER_W-1:0];
                  end
                  scan++;
               end
               if (!found) scan = VALUE_SPACE;
            end
         end
         default: ;
      endcase
      return answers;
   endfunction

   // Check each answer against the oldest one due, then predict for the request taken
   always @(posedge clock) begin : watch
      answer_type  due;
      answer_type  ans;
      request_type req;
      if (reset) begin
         wipe_job();
         sets_wanted = 0;
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (answers_due.size() == 0) begin
               $error("unexpected answer: status %0d, member %0d", rsp_status, rsp_member);
               failures++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  failures++;
               end
               if (rsp_member !== due.member) begin
                  $error("member: expected %0d, got %0d", due.member, rsp_member);
                  failures++;
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            $error("rsp_strobe: expected 0 or 1, got %b", rsp_strobe);
            failures++;
         end
         if (csr_wr_en) sets_wanted = int'(csr_wr_data);
         req_taken <= start && busy === 1'b0;
         if (start && busy === 1'b0) begin
            req.kind  = kind_type'(req_kind);
            req.value = req_value;
            if (step_intersection(req, ans)) answers_due.push_back(ans);
         end
      end
   end

   // Drive requests at the falling edge; hold a request until it is taken
   always @(negedge clock) begin : drive
      request_type req;
      if (!reset && !(start && !req_taken)) begin
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req = pending_requests.pop_front();
            start     <= 1'b1;
            req_kind  <= req.kind;
            req_value <= req.value;
            if (idle_on && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 7);
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic queue_request(input kind_type kind, input int value);
      request_type req;
      req.kind  = kind;
      req.value = value[VALUE_W-1:0];
      pending_requests.push_back(req);
      queued++;
   endtask

   // Wait until every request is taken and every answer has come back
   task automatic wait_quiet();
      while (pending_requests.size() != 0 || start || answers_due.size() != 0)
         @(posedge clock);
   endtask

   // Write set_count once the core has drained, including any clearing sweep
   task automatic write_set_count(input int count);
      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count[SETCNT_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      programmed_sets = count;
   endtask

   // One job: mostly well-formed sorted sets sharing a few values, sometimes broken
   task automatic random_job();
      int                   k;
      int                   span;
      int                   lo;
      int                   where;
      int                   noise;
      int                   last;
      int                   v;
      bit [VALUE_SPACE-1:0] common;
      bit [VALUE_SPACE-1:0] members;
      case ($urandom_range(0, 19))
         0: k = 0;
         1: k = MAX_SETS;
         2: k = $urandom_range(MAX_SETS + 1, 31);
         default: k = $urandom_range(1, 5);
      endcase
      if ($urandom_range(0, 3) != 0) write_set_count(k);
      k = (programmed_sets > MAX_SETS) ? MAX_SETS : programmed_sets;

      // pick a value window and the values every set shares
      span   = ($urandom_range(0, 3) == 0) ? VALUE_SPACE : $urandom_range(8, 64);
      lo     = $urandom_range(0, VALUE_SPACE - span);
      common = '0;
      repeat ($urandom_range(0, 4)) common[lo + $urandom_range(0, span - 1)] = 1'b1;
      if ($urandom_range(0, 7) == 0) common[0] = 1'b1;
      if ($urandom_range(0, 7) == 0) common[VALUE_SPACE-1] = 1'b1;

      noise = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
      where = (k > 0) ? $urandom_range(0, k - 1) : 0;
      queue_request(KIND_START, $urandom);
      for (int s = 0; s < k; s++) begin
         members = common;
         if ($urandom_range(0, 4) == 0) members[lo + $urandom_range(0, span - 1)] = 1'b0;
         repeat ($urandom_range(0, 3)) members[lo + $urandom_range(0, span - 1)] = 1'b1;
         last = 0;
         for (int i = 0; i < VALUE_SPACE; i++) begin
            if (members[i]) begin
               queue_request(KIND_ELEM, i);
               last = i;
            end
         end
         if (s == where) begin
            case (noise)
               1: queue_request(KIND_FETCH, $urandom);
               2: begin
                  case ($urandom_range(0, 2))
                     0: v = -$urandom_range(1, 32768);
                     1: v = $urandom_range(VALUE_SPACE, 32767);
                     default: v = last;
                  endcase
                  queue_request(KIND_ELEM, v);
               end
               5: queue_request(KIND_START, $urandom);
               default: ;
            endcase
         end
         queue_request(KIND_CLOSE, $urandom);
      end
      if (noise == 3) queue_request(KIND_CLOSE, $urandom);
      if (noise == 4) queue_request(KIND_ELEM, lo + $urandom_range(0, span - 1));

      // now and then change the set count between loading and fetching
      if ($urandom_range(0, 11) == 0) write_set_count($urandom_range(0, 6));
      repeat ($countones(common) + $urandom_range(1, 3)) queue_request(KIND_FETCH, $urandom);
   endtask

   initial begin : stimulus
      int base;
      while (reset) @(negedge clock);

      // no sets: empty answer, element after all closed, fetch with error, extra close
      write_set_count(0);
      queue_request(KIND_START, 0);
      queue_request(KIND_FETCH, 0);
      queue_request(KIND_ELEM, -32768);
      queue_request(KIND_FETCH, 0);
      queue_request(KIND_CLOSE, 0);

      // oversized count: value out of range, then a fetch with sets still open
      write_set_count(31);
      queue_request(KIND_START, 0);
      queue_request(KIND_ELEM, 0);
      queue_request(KIND_ELEM, VALUE_SPACE - 1);
      queue_request(KIND_ELEM, VALUE_SPACE);
      queue_request(KIND_FETCH, 0);
      queue_request(KIND_START, 0);
      queue_request(KIND_ELEM, 5);
      queue_request(KIND_CLOSE, 0);
      queue_request(KIND_FETCH, 0);

      // drop the count mid-job: the open job becomes complete, scan to exhaustion
      write_set_count(1);
      queue_request(KIND_CLOSE, 0);
      queue_request(KIND_FETCH, 0);
      queue_request(KIND_FETCH, 0);
      queue_request(KIND_FETCH, 0);

      // repeated element, then elements ignored after the error
      write_set_count(2);
      queue_request(KIND_START, 0);
      queue_request(KIND_ELEM, 9);
      queue_request(KIND_ELEM, 9);
      queue_request(KIND_ELEM, 4);
      queue_request(KIND_FETCH, 0);

      base = queued;
      while (queued - base < RANDOM_REQUESTS) begin
         if (queued - base > RANDOM_REQUESTS * 4 / 5) idle_on = 1'b0;
         random_job();
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("k_set_intersection_core verification clean");
      end else begin
         $display("k_set_intersection_core verification failed");
      end
      $finish;
   end

endmodule
